// ===== src/atrp_pkg.sv =====
// Shared constants and types for the accelerometer tilt block.
`timescale 1ns / 1ps
`default_nettype none
package atrp_pkg;
  localparam int SAMPLE_BITS_DEF  = 10;
  localparam int CORDIC_ITER_DEF  = 16;
  localparam int ATAN_TAB_LEN     = 24;
  localparam int FRAC_SHIFT       = 8;
  localparam int DEG_TO_OUT_SHIFT = 13;
  localparam int ANGLE_W          = 16;
  localparam int Z_W              = 28;
  localparam int TAB_W            = 27;
  localparam int OFFSET_RESET     = 515;
  localparam int CFG_ADDR_W       = 2;

  localparam logic signed [ANGLE_W-1:0] FOLD_LIMIT   = 16'sd5760;
  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 16'sd11520;

  localparam logic [TAB_W-1:0] ATAN_TAB [ATAN_TAB_LEN] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
    27'd1876857,  27'd938658,   27'd469357,   27'd234682,  27'd117342,
    27'd58671,    27'd29335,    27'd14668,    27'd7334,    27'd3667,
    27'd1833,     27'd917,      27'd458,      27'd229,     27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_X_OFFSET = 2'd0,
    REG_Y_OFFSET = 2'd1,
    REG_Z_OFFSET = 2'd2
  } cfg_reg_t;
endpackage
`default_nettype wire

// ===== src/atrp_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module atrp_sqrt #(
  parameter int ROOT_W = 19,
  parameter int RAD_W  = 2 * ROOT_W
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [RAD_W-1:0]  rad_in,
  output logic      [ROOT_W-1:0] root_out
);
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [ROOT_W+1:0] rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_i;
    logic [ROOT_W+1:0] rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [ROOT_W+1:0] rem_t;
    logic [ROOT_W+1:0] trial;
    if (k == 0) begin : g_first
      assign rad_i  = rad_in;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
    end
    assign rem_t = {rem_i[ROOT_W-1:0], rad_i[RAD_W-1 -: 2]};
    assign trial = {root_i, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= rad_i << 2;
        if (rem_t >= trial) begin
          rem_r[k]  <= rem_t - trial;
          root_r[k] <= {root_i[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_t;
          root_r[k] <= {root_i[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_out = root_r[ROOT_W-1];
endmodule
`default_nettype wire

// ===== src/atrp_cordic.sv =====
// Pipelined vectoring CORDIC, atan2 in 1/128 degree.
`timescale 1ns / 1ps
`default_nettype none
module atrp_cordic #(
  parameter int ITER = 16,
  parameter int X_W  = 19,
  parameter int A_W  = 11
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic        [X_W-1:0]                den_in,
  input  wire logic signed [A_W-1:0]                axis_in,
  output logic      signed [atrp_pkg::ANGLE_W-1:0]  angle_out
);
  localparam int NI  = (ITER < atrp_pkg::ATAN_TAB_LEN) ? ITER : atrp_pkg::ATAN_TAB_LEN;
  localparam int CW  = X_W + 3;
  localparam int ZW  = atrp_pkg::Z_W;
  localparam int RW  = ZW - atrp_pkg::DEG_TO_OUT_SHIFT;
  localparam int AW  = atrp_pkg::ANGLE_W;

  logic signed [CW-1:0] x_r [NI];
  logic signed [CW-1:0] y_r [NI];
  logic signed [ZW-1:0] z_r [NI];
  logic                 zero_r [NI];

  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  assign x0 = signed'({3'b000, den_in});
  assign y0 = CW'(axis_in) <<< atrp_pkg::FRAC_SHIFT;

  for (genvar k = 0; k < NI; k++) begin : g_stage
    logic signed [CW-1:0] xi, yi, sx, sy;
    logic signed [ZW-1:0] zi, ang;
    logic                 zfi;
    if (k == 0) begin : g_first
      assign xi  = x0;
      assign yi  = y0;
      assign zi  = '0;
      assign zfi = (den_in == '0) && (axis_in == '0);
    end else begin : g_next
      assign xi  = x_r[k-1];
      assign yi  = y_r[k-1];
      assign zi  = z_r[k-1];
      assign zfi = zero_r[k-1];
    end
    assign sx  = xi >>> k;
    assign sy  = yi >>> k;
    assign ang = signed'({1'b0, atrp_pkg::ATAN_TAB[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[k] <= zfi;
        if (!yi[CW-1]) begin
          x_r[k] <= xi + sy;
          y_r[k] <= yi - sx;
          z_r[k] <= zi + ang;
        end else begin
          x_r[k] <= xi - sy;
          y_r[k] <= yi + sx;
          z_r[k] <= zi - ang;
        end
      end
    end
  end

  logic        [ZW-1:0] mag;
  logic        [ZW-1:0] mag_rnd;
  logic        [RW-1:0] rnd;
  logic signed [AW-1:0] angle_nxt;
  always_comb begin
    mag     = z_r[NI-1][ZW-1] ? ZW'(-z_r[NI-1]) : ZW'(z_r[NI-1]);
    mag_rnd = mag + ZW'(1 << (atrp_pkg::DEG_TO_OUT_SHIFT - 1));
    rnd     = mag_rnd[ZW-1:atrp_pkg::DEG_TO_OUT_SHIFT];
    if (zero_r[NI-1]) begin
      angle_nxt = '0;
    end else if (z_r[NI-1][ZW-1]) begin
      angle_nxt = -AW'(rnd);
    end else begin
      angle_nxt = AW'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_out <= angle_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/accel_tilt_roll_pitch_top.sv =====
// Top level: roll and pitch from one three-axis accelerometer word.
// Pipeline depth follows SAMPLE_BITS and CORDIC_ITERATIONS (capped by the atan table),
// set by the square root (one root bit per stage) and CORDIC (one iteration per stage).
// Throughput: one word per cycle; a stall on the output holds the whole pipeline.
// Reset (synchronous, rst_n low) clears all valid bits and sets every offset to 515.
`timescale 1ns / 1ps
`default_nettype none
module accel_tilt_roll_pitch_top #(
  parameter int SAMPLE_BITS       = atrp_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_ITERATIONS = atrp_pkg::CORDIC_ITER_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // x_sample, y_sample, z_sample, zero pad
  input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // roll_angle, pitch_angle
  output logic [2*atrp_pkg::ANGLE_W-1:0]            out_tdata,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [atrp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [SAMPLE_BITS-1:0]               cfg_wdata
);
  localparam int S      = SAMPLE_BITS;
  localparam int D_W    = S + 1;
  localparam int SQ_W   = 2 * S + 1;
  localparam int ROOT_W = S + atrp_pkg::FRAC_SHIFT + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int NI     = (CORDIC_ITERATIONS < atrp_pkg::ATAN_TAB_LEN) ?
                          CORDIC_ITERATIONS : atrp_pkg::ATAN_TAB_LEN;
  localparam int LAT    = ROOT_W + NI + 4;
  localparam int AW     = atrp_pkg::ANGLE_W;

  logic [S-1:0] x_off_r, y_off_r, z_off_r;
  logic         en;
  logic [LAT-1:0] v_r;

  assign en         = !v_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r <= S'(atrp_pkg::OFFSET_RESET);
      y_off_r <= S'(atrp_pkg::OFFSET_RESET);
      z_off_r <= S'(atrp_pkg::OFFSET_RESET);
    end else if (cfg_wr_en) begin
      unique case (atrp_pkg::cfg_reg_t'(cfg_addr))
        atrp_pkg::REG_X_OFFSET: x_off_r <= cfg_wdata;
        atrp_pkg::REG_Y_OFFSET: y_off_r <= cfg_wdata;
        atrp_pkg::REG_Z_OFFSET: z_off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  // offset subtract
  logic signed [D_W-1:0] dx_r, dy_r, dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= signed'({1'b0, in_tdata[S-1:0]})     - signed'({1'b0, x_off_r});
      dy_r <= signed'({1'b0, in_tdata[2*S-1:S]})   - signed'({1'b0, y_off_r});
      dz_r <= signed'({1'b0, in_tdata[3*S-1:2*S]}) - signed'({1'b0, z_off_r});
    end
  end

  // squares and sums
  logic signed [2*D_W-1:0] pxx, pyy, pzz;
  logic [SQ_W-1:0] s_xy_r, s_yz_r, s_xz_r;
  assign pxx = dx_r * dx_r;
  assign pyy = dy_r * dy_r;
  assign pzz = dz_r * dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s_xy_r <= {1'b0, pxx[2*S-1:0]} + {1'b0, pyy[2*S-1:0]};
      s_yz_r <= {1'b0, pyy[2*S-1:0]} + {1'b0, pzz[2*S-1:0]};
      s_xz_r <= {1'b0, pxx[2*S-1:0]} + {1'b0, pzz[2*S-1:0]};
    end
  end

  logic [3*D_W-1:0] dl_r [ROOT_W+1];
  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= {dz_r, dy_r, dx_r};
      for (int j = 1; j <= ROOT_W; j++) begin
        dl_r[j] <= dl_r[j-1];
      end
    end
  end

  logic [ROOT_W-1:0] mag_xy, mag_yz, mag_xz;
  atrp_sqrt #(.ROOT_W(ROOT_W), .RAD_W(RAD_W)) u_sqrt_xy (
    .clk(clk), .en(en),
    .rad_in({1'b0, s_xy_r, (2*atrp_pkg::FRAC_SHIFT)'(0)}), .root_out(mag_xy));
  atrp_sqrt #(.ROOT_W(ROOT_W), .RAD_W(RAD_W)) u_sqrt_yz (
    .clk(clk), .en(en),
    .rad_in({1'b0, s_yz_r, (2*atrp_pkg::FRAC_SHIFT)'(0)}), .root_out(mag_yz));
  atrp_sqrt #(.ROOT_W(ROOT_W), .RAD_W(RAD_W)) u_sqrt_xz (
    .clk(clk), .en(en),
    .rad_in({1'b0, s_xz_r, (2*atrp_pkg::FRAC_SHIFT)'(0)}), .root_out(mag_xz));

  logic signed [D_W-1:0] ax, ay, az;
  assign ax = signed'(dl_r[ROOT_W][D_W-1:0]);
  assign ay = signed'(dl_r[ROOT_W][2*D_W-1:D_W]);
  assign az = signed'(dl_r[ROOT_W][3*D_W-1:2*D_W]);

  logic signed [AW-1:0] roll_a, pitch_a, fold_lo, fold_hi;
  atrp_cordic #(.ITER(CORDIC_ITERATIONS), .X_W(ROOT_W), .A_W(D_W)) u_cordic_roll (
    .clk(clk), .en(en), .den_in(mag_yz), .axis_in(-ax), .angle_out(roll_a));
  atrp_cordic #(.ITER(CORDIC_ITERATIONS), .X_W(ROOT_W), .A_W(D_W)) u_cordic_pitch (
    .clk(clk), .en(en), .den_in(mag_xz), .axis_in(-ay), .angle_out(pitch_a));
  atrp_cordic #(.ITER(CORDIC_ITERATIONS), .X_W(ROOT_W), .A_W(D_W)) u_cordic_lo (
    .clk(clk), .en(en), .den_in(mag_xy), .axis_in(az), .angle_out(fold_lo));
  atrp_cordic #(.ITER(CORDIC_ITERATIONS), .X_W(ROOT_W), .A_W(D_W)) u_cordic_hi (
    .clk(clk), .en(en), .den_in(mag_xy), .axis_in(-az), .angle_out(fold_hi));

  logic signed [AW-1:0] roll_nxt, pitch_nxt;
  always_comb begin
    if (roll_a < -atrp_pkg::FOLD_LIMIT) begin
      roll_nxt = fold_lo - atrp_pkg::QUARTER_TURN;
    end else if (roll_a > atrp_pkg::FOLD_LIMIT) begin
      roll_nxt = fold_hi + atrp_pkg::QUARTER_TURN;
    end else begin
      roll_nxt = roll_a;
    end
    if (pitch_a < -atrp_pkg::FOLD_LIMIT) begin
      pitch_nxt = fold_lo - atrp_pkg::QUARTER_TURN;
    end else if (pitch_a > atrp_pkg::FOLD_LIMIT) begin
      pitch_nxt = fold_hi + atrp_pkg::QUARTER_TURN;
    end else begin
      pitch_nxt = pitch_a;
    end
  end

  logic [2*AW-1:0] out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= {pitch_nxt, roll_nxt};
    end
  end
  assign out_tdata = out_r;
endmodule
`default_nettype wire

// ===== src/atrp_checker.sv =====
// Port-level checks for the tilt block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module atrp_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [2*atrp_pkg::ANGLE_W-1:0]     out_tdata
);
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled word changed");

  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output side");

  a_no_stall_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input held off with nothing waiting");
endmodule

bind accel_tilt_roll_pitch_top atrp_checker u_atrp_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

// ===== dv/tilt_checker.sv =====
// Checker: predicts roll and pitch per accepted sample and compares each result word.
`timescale 1ns / 1ps
module tilt_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [31:0]                     in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [31:0]                     out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [atrp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [9:0]                      cfg_wdata,
  output int                              fail_count,
  output int                              angles_pending
);
  import atrp_pkg::*;

  typedef struct {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
  } tilt_t;

  tilt_t       tilt_q[$];
  logic [9:0]  x_off, y_off, z_off;

  function automatic longint isqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint vec_len(longint p, longint q);
    return isqrt((p * p + q * q) <<< (2 * FRAC_SHIFT));
  endfunction

  function automatic longint atan2_deg(longint num, longint den);
    longint cx, cy, acc, sx, sy, m, r;
    cx = den;
    cy = num <<< FRAC_SHIFT;
    acc = 0;
    if (cx == 0 && cy == 0) return 0;
    for (int i = 0; i < CORDIC_ITER_DEF && i < ATAN_TAB_LEN; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy >= 0) begin
        cx = cx + sy;
        cy = cy - sx;
        acc = acc + longint'(ATAN_TAB[i]);
      end else begin
        cx = cx - sy;
        cy = cy + sx;
        acc = acc - longint'(ATAN_TAB[i]);
      end
    end
    m = acc < 0 ? -acc : acc;
    r = (m + (64'sd1 <<< (DEG_TO_OUT_SHIFT - 1))) >>> DEG_TO_OUT_SHIFT;
    return acc < 0 ? -r : r;
  endfunction

  function automatic longint fold_angle(longint a, longint dz, longint flat);
    if (a < -longint'(FOLD_LIMIT)) return -longint'(QUARTER_TURN) + atan2_deg(dz, flat);
    if (a > longint'(FOLD_LIMIT)) return longint'(QUARTER_TURN) + atan2_deg(-dz, flat);
    return a;
  endfunction

  function automatic tilt_t predict_tilt(logic [31:0] w);
    longint dx, dy, dz, flat;
    tilt_t t;
    dx = longint'(w[9:0]) - longint'(x_off);
    dy = longint'(w[19:10]) - longint'(y_off);
    dz = longint'(w[29:20]) - longint'(z_off);
    flat = vec_len(dx, dy);
    t.roll = ANGLE_W'(fold_angle(atan2_deg(-dx, vec_len(dy, dz)), dz, flat));
    t.pitch = ANGLE_W'(fold_angle(atan2_deg(-dy, vec_len(dx, dz)), dz, flat));
    return t;
  endfunction

  always @(posedge clk) begin
    tilt_t e;
    if (!rst_n) begin
      x_off <= 10'(OFFSET_RESET);
      y_off <= 10'(OFFSET_RESET);
      z_off <= 10'(OFFSET_RESET);
      tilt_q.delete();
      fail_count <= 0;
      angles_pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_X_OFFSET: x_off <= cfg_wdata;
          REG_Y_OFFSET: y_off <= cfg_wdata;
          REG_Z_OFFSET: z_off <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (tilt_q.size() == 0) begin
          $error("result word with no pending sample: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = tilt_q.pop_front();
          if (out_tdata[15:0] !== e.roll || out_tdata[31:16] !== e.pitch) begin
            if (out_tdata[15:0] !== e.roll)
              $error("roll_angle: expected %0d, got %0d", e.roll, $signed(out_tdata[15:0]));
            if (out_tdata[31:16] !== e.pitch)
              $error("pitch_angle: expected %0d, got %0d", e.pitch,
                     $signed(out_tdata[31:16]));
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) tilt_q.push_back(predict_tilt(in_tdata));
      angles_pending <= tilt_q.size();
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives samples and offset writes into the tilt block and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  import atrp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam int LATENCY = 39;
  localparam int CYCLE_LIMIT = 300000;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_wr_en;
  logic [31:0] in_tdata, out_tdata;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [9:0] cfg_wdata;
  int fail_count, angles_pending, cycles;
  bit idle_on;

  accel_tilt_roll_pitch_top dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_wr_en, .cfg_addr, .cfg_wdata
  );

  tilt_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_wr_en, .cfg_addr, .cfg_wdata, .fail_count, .angles_pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= !idle_on || ($urandom_range(99) >= 19);

  task automatic send_sample(logic [9:0] x, logic [9:0] y, logic [9:0] z);
    if (idle_on && $urandom_range(99) < 19) begin
      in_tvalid <= 0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {2'b0, z, y, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(negedge clk);
    while (angles_pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_offset(logic [CFG_ADDR_W-1:0] a, logic [9:0] v);
    cfg_wr_en <= 1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic set_offsets(logic [9:0] x, logic [9:0] y, logic [9:0] z);
    drain();
    write_offset(REG_X_OFFSET, x);
    write_offset(REG_Y_OFFSET, y);
    write_offset(REG_Z_OFFSET, z);
  endtask

  task automatic random_samples(int n);
    logic [9:0] c;
    for (int i = 0; i < n; i++) begin
      c = 10'($urandom_range(1023));
      if ($urandom_range(99) < 50)
        send_sample(10'($urandom), 10'($urandom), 10'($urandom));
      else
        send_sample(c + 10'($urandom_range(300)) - 10'd150,
                    c + 10'($urandom_range(300)) - 10'd150,
                    c + 10'($urandom_range(300)) - 10'd150);
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    out_tready = 0;
    cfg_wr_en = 0;
    cfg_addr = REG_X_OFFSET;
    cfg_wdata = 0;
    cycles = 0;
    idle_on = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_sample(10'd515, 10'd515, 10'd515);
    send_sample(10'd0, 10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023, 10'd1023);
    send_sample(10'd0, 10'd515, 10'd515);
    send_sample(10'd1023, 10'd515, 10'd515);
    send_sample(10'd515, 10'd0, 10'd515);
    send_sample(10'd515, 10'd1023, 10'd515);
    send_sample(10'd515, 10'd515, 10'd0);
    send_sample(10'd515, 10'd515, 10'd1023);
    send_sample(10'd415, 10'd515, 10'd615);
    send_sample(10'd615, 10'd515, 10'd415);
    send_sample(10'd416, 10'd615, 10'd614);
    send_sample(10'd0, 10'd1023, 10'd0);
    send_sample(10'd1023, 10'd0, 10'd1023);
    send_sample(10'd715, 10'd315, 10'd515);
    random_samples(300);

    set_offsets(10'd0, 10'd0, 10'd0);
    write_offset(REG_UNUSED, 10'd77);
    send_sample(10'd0, 10'd0, 10'd0);
    random_samples(300);

    set_offsets(10'd1023, 10'd1023, 10'd1023);
    send_sample(10'd1023, 10'd1023, 10'd1023);
    send_sample(10'd0, 10'd0, 10'd0);
    idle_on = 0;
    random_samples(300);
    idle_on = 1;

    for (int p = 0; p < 3; p++) begin
      set_offsets(10'($urandom), 10'($urandom), 10'($urandom));
      random_samples(280);
    end

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
